[rtl/ppq_pkg.sv]
// Package for the packet playout queue: sizes, codes, RAM word layout and the
// command and status bundles shared by the controller and the datapath.
// No dependencies.
package ppq_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int LEN_W     = 12;
  localparam int SPAN_W    = 16;
  localparam int QSPAN_W   = 22;
  localparam int TICK_W    = 16;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 3;

  localparam logic [LEN_W-1:0]   MAX_BYTES_RST  = LEN_W'(1024);
  localparam logic [QSPAN_W-1:0] HIGH_WATER_RST = QSPAN_W'(9600);
  localparam logic [QSPAN_W-1:0] PREBUF_RST     = QSPAN_W'(1920);
  localparam logic [TICK_W-1:0]  RETIRE_RST     = TICK_W'(10);
  localparam logic [TICK_W-1:0]  STALL_RST      = TICK_W'(100);

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_POP   = 2'd1,
    OP_TICK  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_TOO_BIG   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BYTES  = 3'd0,
    CFG_HIGH_WATER = 3'd1,
    CFG_PREBUF     = 3'd2,
    CFG_RETIRE     = 3'd3,
    CFG_STALL      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [SPAN_W-1:0] span;
  } slot_t;

  typedef struct packed {
    logic    capture;
    logic    set_status;
    status_e status;
    logic    drop_head;
    logic    insert;
    logic    pop_commit;
    logic    gate_set;
    logic    term_latch;
    logic    tick;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic oversize;
    logic unpriced;
    logic len_zero;
    logic full;
    logic empty;
    logic over_hw;
    logic gate_short;
  } sts_t;

endpackage

[rtl/packet_playout_queue.sv]
// Top level of the packet playout queue: joins the controller and the datapath.
// Depends on ppq_pkg, ppq_ctrl, ppq_datapath.
//
// Input channel (in_valid_i / in_stall_o) carries one transaction per command:
// offer a packet, pop the head packet, or end a tick. Every transaction yields
// exactly one result on the output channel (out_valid_o / out_stall_i) with a
// status, the slot index, the popped length, the drop count and the retire flag.
// Payload bytes are kept outside in a pool addressed by slot_index_o. An offer
// that is neither refused nor empty drops the head slot first when the ring is
// full, then after the insert drops head slots one at a time while above the
// high-water mark, each drop reading the head slot span through the registered
// read port of the slot RAM. A new transaction is taken in the cycle after the
// result is loaded; the next one enters while that result still waits on the
// output. A stalled result holds; the controller waits in its last state until
// the output register is free. Reset clears pointers, counts, span, gate, idle
// count and restores the register defaults; slot contents stay undefined. The
// user must write configuration (cfg_we_i, cfg_index_i, cfg_data_i) only while
// idle; the block does not enforce it.
module packet_playout_queue import ppq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [LEN_W-1:0]     pkt_len_i,
  input  logic [SPAN_W-1:0]    span_samples_i,
  input  logic                 terminator_i,
  input  logic [LEN_W-1:0]     out_capacity_i,
  input  logic                 produced_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [SLOT_W-1:0]    slot_index_o,
  output logic [LEN_W-1:0]     out_len_o,
  output logic [CNT_W-1:0]     dropped_o,
  output logic                 retire_o
);

  cmd_t cmd;
  sts_t sts;

  ppq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .pkt_len_i     (pkt_len_i),
    .span_samples_i(span_samples_i),
    .terminator_i  (terminator_i),
    .out_capacity_i(out_capacity_i),
    .produced_i    (produced_i),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .out_len_o     (out_len_o),
    .dropped_o     (dropped_o),
    .retire_o      (retire_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("controller idle right after an accepted transaction");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in progress");

  a_drop_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o != '0) |-> (status_o == ST_OK && !retire_o))
    else $error("drop count reported on a failed or non-offer transaction");

endmodule

[rtl/ppq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ppq_ctrl.sv]
// Controller state machine of the packet playout queue: sequences offer, pop
// and tick transactions and owns the result valid flag. Depends on ppq_pkg.
module ppq_ctrl import ppq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FULL_DROP,
    S_INSERT,
    S_CHECK,
    S_HW_DROP,
    S_POP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        unique case (sts_i.op)
          OP_OFFER: begin
            if (sts_i.oversize) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_REFUSED;
            end else if (sts_i.unpriced) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_REFUSED;
              cmd_o.term_latch = 1'b1;
            end else if (sts_i.len_zero) begin
              cmd_o.term_latch = 1'b1;
            end else if (sts_i.full) begin
              state_d = S_FULL_DROP;
            end else begin
              state_d = S_INSERT;
            end
          end
          OP_POP: begin
            if (sts_i.gate_short) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NOT_READY;
            end else begin
              cmd_o.gate_set = 1'b1;
              if (sts_i.empty) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = ST_NOT_READY;
              end else begin
                state_d = S_POP;
              end
            end
          end
          OP_TICK: begin
            cmd_o.tick = 1'b1;
          end
          OP_RSVD: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_REFUSED;
          end
        endcase
      end
      S_FULL_DROP: begin
        cmd_o.drop_head = 1'b1;
        state_d = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.over_hw) begin
          state_d = S_HW_DROP;
        end else begin
          cmd_o.term_latch = 1'b1;
          state_d = S_DONE;
        end
      end
      S_HW_DROP: begin
        cmd_o.drop_head = 1'b1;
        state_d = S_CHECK;
      end
      S_POP: begin
        cmd_o.pop_commit = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/ppq_datapath.sv]
// Datapath of the packet playout queue: configuration registers, ring pointers,
// span accounting, slot RAM and result registers. Depends on ppq_pkg, ppq_ram.
module ppq_datapath import ppq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [1:0]           op_i,
  input  logic [LEN_W-1:0]     pkt_len_i,
  input  logic [SPAN_W-1:0]    span_samples_i,
  input  logic                 terminator_i,
  input  logic [LEN_W-1:0]     out_capacity_i,
  input  logic                 produced_i,
  output logic [1:0]           status_o,
  output logic [SLOT_W-1:0]    slot_index_o,
  output logic [LEN_W-1:0]     out_len_o,
  output logic [CNT_W-1:0]     dropped_o,
  output logic                 retire_o
);

  logic [LEN_W-1:0]   max_bytes_q;
  logic [QSPAN_W-1:0] high_water_q;
  logic [QSPAN_W-1:0] prebuf_q;
  logic [TICK_W-1:0]  retire_ticks_q;
  logic [TICK_W-1:0]  stall_ticks_q;

  op_e               op_q;
  logic [LEN_W-1:0]  len_q;
  logic [SPAN_W-1:0] span_q;
  logic              term_q;
  logic [LEN_W-1:0]  cap_q;
  logic              produced_q;

  logic [SLOT_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [QSPAN_W-1:0] qspan_q, qspan_d;
  logic               gate_q, gate_d;
  logic [TICK_W-1:0]  idle_q, idle_d;

  status_e           res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [LEN_W-1:0]  res_len_q;
  logic [CNT_W-1:0]  res_dropped_q;
  logic              res_retire_q;

  status_e           out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [CNT_W-1:0]  out_dropped_q;
  logic              out_retire_q;

  slot_t             ram_rd;
  slot_t             ram_wr;
  logic [CNT_W:0]    tail_sum;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] head_nxt;
  logic              fits;
  logic              adv;
  logic              drained;
  logic [TICK_W-1:0] idle_nxt;
  logic              retire_now;

  assign ram_wr.len  = len_q;
  assign ram_wr.span = span_q;

  ppq_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.insert),
    .waddr_i(tail),
    .wdata_i(ram_wr),
    .raddr_i(head_q),
    .rdata_o(ram_rd)
  );

  always_comb begin
    tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
    if (tail_sum >= (CNT_W+1)'(SLOTS)) begin
      tail = SLOT_W'(tail_sum - (CNT_W+1)'(SLOTS));
    end else begin
      tail = SLOT_W'(tail_sum);
    end
    head_nxt = (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
    fits     = (ram_rd.len <= cap_q);
    adv      = cmd_i.drop_head || (cmd_i.pop_commit && fits);
    drained  = (count_q == '0);
    if (produced_q) begin
      idle_nxt = '0;
    end else if (idle_q == '1) begin
      idle_nxt = idle_q;
    end else begin
      idle_nxt = idle_q + 1'b1;
    end
    retire_now = (idle_nxt >= (drained ? retire_ticks_q : stall_ticks_q));
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    qspan_d = qspan_q;
    gate_d  = gate_q;
    idle_d  = idle_q;
    if (cmd_i.insert) begin
      count_d = count_q + 1'b1;
      qspan_d = qspan_q + QSPAN_W'(span_q);
    end else if (adv) begin
      head_d  = head_nxt;
      count_d = count_q - 1'b1;
      qspan_d = qspan_q - QSPAN_W'(ram_rd.span);
    end
    if (cmd_i.gate_set || (cmd_i.term_latch && term_q)) begin
      gate_d = 1'b1;
    end else if (cmd_i.tick && !produced_q && drained) begin
      gate_d = 1'b0;
    end
    if (cmd_i.tick) begin
      idle_d = idle_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q    <= MAX_BYTES_RST;
      high_water_q   <= HIGH_WATER_RST;
      prebuf_q       <= PREBUF_RST;
      retire_ticks_q <= RETIRE_RST;
      stall_ticks_q  <= STALL_RST;
      head_q         <= '0;
      count_q        <= '0;
      qspan_q        <= '0;
      gate_q         <= 1'b0;
      idle_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MAX_BYTES:  max_bytes_q    <= cfg_data_i[LEN_W-1:0];
          CFG_HIGH_WATER: high_water_q   <= cfg_data_i[QSPAN_W-1:0];
          CFG_PREBUF:     prebuf_q       <= cfg_data_i[QSPAN_W-1:0];
          CFG_RETIRE:     retire_ticks_q <= cfg_data_i[TICK_W-1:0];
          CFG_STALL:      stall_ticks_q  <= cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end
      head_q  <= head_d;
      count_q <= count_d;
      qspan_q <= qspan_d;
      gate_q  <= gate_d;
      idle_q  <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q          <= op_e'(op_i);
      len_q         <= pkt_len_i;
      span_q        <= span_samples_i;
      term_q        <= terminator_i;
      cap_q         <= out_capacity_i;
      produced_q    <= produced_i;
      res_status_q  <= ST_OK;
      res_slot_q    <= '0;
      res_len_q     <= '0;
      res_dropped_q <= '0;
      res_retire_q  <= 1'b0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.insert) begin
        res_slot_q <= tail;
      end
      if (cmd_i.drop_head) begin
        res_dropped_q <= res_dropped_q + 1'b1;
      end
      if (cmd_i.pop_commit) begin
        res_slot_q <= head_q;
        res_len_q  <= ram_rd.len;
        if (!fits) begin
          res_status_q <= ST_TOO_BIG;
        end
      end
      if (cmd_i.tick) begin
        res_retire_q <= retire_now;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q  <= res_status_q;
      out_slot_q    <= res_slot_q;
      out_len_q     <= res_len_q;
      out_dropped_q <= res_dropped_q;
      out_retire_q  <= res_retire_q;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.oversize   = (len_q > max_bytes_q);
  assign sts_o.unpriced   = (len_q != '0) && (span_q == '0);
  assign sts_o.len_zero   = (len_q == '0);
  assign sts_o.full       = (count_q == CNT_W'(SLOTS));
  assign sts_o.empty      = drained;
  assign sts_o.over_hw    = (qspan_q > high_water_q) && (count_q > CNT_W'(1));
  assign sts_o.gate_short = !gate_q && (qspan_q < prebuf_q);

  assign status_o     = out_status_q;
  assign slot_index_o = out_slot_q;
  assign out_len_o    = out_len_q;
  assign dropped_o    = out_dropped_q;
  assign retire_o     = out_retire_q;

endmodule

[tb/tb.sv]
// Self-checking testbench for packet_playout_queue: directed and random offer, pop
// and tick transactions checked against a cycle-free predictor of the slot ring.
// Depends on ppq_pkg and the packet_playout_queue RTL.
`timescale 1ns / 1ps

module tb;
  import ppq_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int WD_LIMIT      = 4000;
  localparam int MAX_REPORTS   = 30;

  typedef struct packed {
    op_e               op;
    logic [LEN_W-1:0]  pkt_len;
    logic [SPAN_W-1:0] span;
    logic              term;
    logic [LEN_W-1:0]  cap;
    logic              produced;
  } playout_req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic [CNT_W-1:0]  dropped;
    logic              retire;
  } playout_rsp_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           op_i;
  logic [LEN_W-1:0]     pkt_len_i;
  logic [SPAN_W-1:0]    span_samples_i;
  logic                 terminator_i;
  logic [LEN_W-1:0]     out_capacity_i;
  logic                 produced_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic [SLOT_W-1:0]    slot_index_o;
  logic [LEN_W-1:0]     out_len_o;
  logic [CNT_W-1:0]     dropped_o;
  logic                 retire_o;

  packet_playout_queue DUT (.*);

  // predictor state and register copies
  logic [LEN_W-1:0]   cfg_max_bytes;
  logic [QSPAN_W-1:0] cfg_high_water;
  logic [QSPAN_W-1:0] cfg_prebuf;
  logic [TICK_W-1:0]  cfg_retire;
  logic [TICK_W-1:0]  cfg_stall;
  logic [LEN_W-1:0]   ring_len [SLOTS];
  logic [SPAN_W-1:0]  ring_spn [SLOTS];
  logic [SLOT_W-1:0]  ring_head;
  logic [CNT_W-1:0]   ring_count;
  logic [QSPAN_W-1:0] ring_span;
  logic               ring_gate;
  logic [TICK_W-1:0]  ring_idle;

  playout_rsp_t expected_rsp [$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_serial;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned wd_count;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_cfg_writes;
  int unsigned n_dropped;
  int unsigned n_full_drops;
  int unsigned status_seen [4];

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void drop_oldest();
    ring_span  = ring_span - QSPAN_W'(ring_spn[ring_head]);
    ring_head  = (int'(ring_head) + 1 >= SLOTS) ? '0 : ring_head + 1'b1;
    ring_count = ring_count - 1'b1;
  endfunction

  function automatic playout_rsp_t predict_playout(input playout_req_t r);
    playout_rsp_t      rsp;
    int unsigned       tail;
    int unsigned       drops;
    logic              priced;
    logic              drained;
    logic [TICK_W-1:0] limit;
    rsp   = '0;
    drops = 0;
    case (r.op)
      OP_OFFER: begin
        if (r.pkt_len > cfg_max_bytes) begin
          rsp.status = ST_REFUSED;
        end else begin
          priced = (r.pkt_len == '0) || (r.span != '0);
          if (priced && r.pkt_len != '0) begin
            if (int'(ring_count) >= SLOTS) begin
              drop_oldest();
              drops++;
              n_full_drops++;
            end
            tail = int'(ring_head) + int'(ring_count);
            if (tail >= SLOTS) tail -= SLOTS;
            ring_len[tail] = r.pkt_len;
            ring_spn[tail] = r.span;
            ring_count     = ring_count + 1'b1;
            ring_span      = ring_span + QSPAN_W'(r.span);
            rsp.slot       = SLOT_W'(tail);
            while (ring_span > cfg_high_water && ring_count > 1) begin
              drop_oldest();
              drops++;
            end
          end
          if (r.term) ring_gate = 1'b1;
          rsp.status = priced ? ST_OK : ST_REFUSED;
        end
        rsp.dropped = CNT_W'(drops);
        n_dropped += drops;
      end
      OP_POP: begin
        if (!ring_gate && ring_span < cfg_prebuf) begin
          rsp.status = ST_NOT_READY;
        end else begin
          ring_gate = 1'b1;
          if (ring_count == '0) begin
            rsp.status = ST_NOT_READY;
          end else begin
            rsp.slot = ring_head;
            rsp.len  = ring_len[ring_head];
            if (rsp.len > r.cap) rsp.status = ST_TOO_BIG;
            else drop_oldest();
          end
        end
      end
      OP_TICK: begin
        drained = (ring_count == '0);
        if (r.produced) ring_idle = '0;
        else if (ring_idle != '1) ring_idle = ring_idle + 1'b1;
        if (!r.produced && drained) ring_gate = 1'b0;
        limit      = drained ? cfg_retire : cfg_stall;
        rsp.retire = (ring_idle >= limit);
      end
      default: rsp.status = ST_REFUSED;
    endcase
    return rsp;
  endfunction

  function automatic playout_req_t mk_offer(input int unsigned len, input int unsigned span,
                                            input logic term);
    playout_req_t r;
    r         = '0;
    r.op      = OP_OFFER;
    r.pkt_len = LEN_W'(len);
    r.span    = SPAN_W'(span);
    r.term    = term;
    return r;
  endfunction

  function automatic playout_req_t mk_pop(input int unsigned cap);
    playout_req_t r;
    r     = '0;
    r.op  = OP_POP;
    r.cap = LEN_W'(cap);
    return r;
  endfunction

  function automatic playout_req_t mk_tick(input logic produced);
    playout_req_t r;
    r          = '0;
    r.op       = OP_TICK;
    r.produced = produced;
    return r;
  endfunction

  function automatic playout_req_t rand_req(input int unsigned offer_pct,
                                            input int unsigned pop_pct,
                                            input int unsigned tick_pct,
                                            input int unsigned span_hi);
    playout_req_t r;
    int unsigned  pick;
    pick = $urandom_range(99);
    if (pick < offer_pct) r.op = OP_OFFER;
    else if (pick < offer_pct + pop_pct) r.op = OP_POP;
    else if (pick < offer_pct + pop_pct + tick_pct) r.op = OP_TICK;
    else r.op = OP_RSVD;
    case ($urandom_range(9))
      0:       r.pkt_len = '0;
      1:       r.pkt_len = LEN_W'($urandom);
      2:       r.pkt_len = '1;
      default: r.pkt_len = LEN_W'($urandom_range(cfg_max_bytes));
    endcase
    case ($urandom_range(9))
      0:       r.span = '0;
      1:       r.span = SPAN_W'($urandom);
      default: r.span = SPAN_W'($urandom_range(span_hi, 1));
    endcase
    r.term = ($urandom_range(99) < 12);
    case ($urandom_range(3))
      0:       r.cap = LEN_W'($urandom);
      1:       r.cap = LEN_W'($urandom_range(255));
      default: r.cap = LEN_W'($urandom_range(4095, 1024));
    endcase
    r.produced = ($urandom_range(1) != 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (n_errors < MAX_REPORTS)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic send_req(input playout_req_t r);
    playout_rsp_t rsp;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= r.op;
    pkt_len_i      <= r.pkt_len;
    span_samples_i <= r.span;
    terminator_i   <= r.term;
    out_capacity_i <= r.cap;
    produced_i     <= r.produced;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rsp = predict_playout(r);
    expected_rsp.push_back(rsp);
    status_seen[rsp.status]++;
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_BYTES:  cfg_max_bytes  = LEN_W'(value);
      CFG_HIGH_WATER: cfg_high_water = QSPAN_W'(value);
      CFG_PREBUF:     cfg_prebuf     = QSPAN_W'(value);
      CFG_RETIRE:     cfg_retire     = TICK_W'(value);
      CFG_STALL:      cfg_stall      = TICK_W'(value);
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic set_regs(input int unsigned max_bytes, input int unsigned high_water,
                          input int unsigned prebuf, input int unsigned retire,
                          input int unsigned stall);
    write_reg(CFG_MAX_BYTES, max_bytes);
    write_reg(CFG_HIGH_WATER, high_water);
    write_reg(CFG_PREBUF, prebuf);
    write_reg(CFG_RETIRE, retire);
    write_reg(CFG_STALL, stall);
  endtask

  task automatic run_burst(input int unsigned count, input int unsigned offer_pct,
                           input int unsigned pop_pct, input int unsigned tick_pct,
                           input int unsigned span_hi);
    repeat (count) send_req(rand_req(offer_pct, pop_pct, tick_pct, span_hi));
  endtask

  task automatic test_directed();
    playout_req_t rsvd;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rsvd           = '1;
    rsvd.op        = OP_RSVD;
    send_req(mk_offer(0, 0, 1'b0));
    send_req(mk_offer(1025, 50, 1'b1));
    send_req(mk_pop(4095));
    send_req(mk_offer(7, 0, 1'b1));
    send_req(mk_offer(20, 10, 1'b0));
    send_req(mk_pop(4095));
    send_req(mk_pop(4095));
    send_req(mk_tick(1'b0));
    send_req(mk_offer(1024, 1000, 1'b0));
    send_req(mk_pop(4095));
    send_req(mk_offer(500, 1000, 1'b0));
    send_req(mk_pop(100));
    send_req(mk_pop(1024));
    send_req(mk_pop(500));
    send_req(mk_offer(1, 65535, 1'b0));
    send_req(mk_offer(2, 1, 1'b1));
    send_req(mk_tick(1'b0));
    send_req(mk_tick(1'b1));
    send_req(rsvd);
    send_req(mk_offer(4095, 65535, 1'b1));
    send_req(mk_pop(0));
    send_req(mk_pop(4095));
    write_reg(CFG_RETIRE, 0);
    send_req(mk_tick(1'b1));
    write_reg(CFG_MAX_BYTES, 0);
    send_req(mk_offer(1, 1, 1'b0));
    send_req(mk_offer(0, 5, 1'b1));
  endtask

  task automatic test_ring_fill();
    set_regs(4095, 4194303, 4194303, 65535, 65535);
    src_idle_pct   = 60;
    sink_stall_pct = 0;
    // fill past the ring size so the oldest slot is pushed out
    run_burst(80, 100, 0, 0, 2000);
    run_burst(120, 60, 25, 13, 2000);
  endtask

  task automatic test_zero_regs();
    set_regs(0, 0, 0, 0, 0);
    src_idle_pct   = 0;
    sink_stall_pct = 60;
    run_burst(150, 40, 35, 23, 500);
  endtask

  task automatic test_backpressure();
    set_regs(2048, 200000, 500, 20, 50);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_serial++;
    run_burst(150, 60, 30, 8, 1000);
  endtask

  task automatic test_random_traffic();
    int unsigned hw;
    int unsigned span_hi;
    int unsigned prebuf;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(3))
        0:       hw = $urandom_range(3000);
        1:       hw = $urandom_range(60000, 3000);
        2:       hw = 4194303;
        default: hw = $urandom_range(4194303);
      endcase
      span_hi = hw / 6 + 1;
      if (span_hi > 65535) span_hi = 65535;
      case ($urandom_range(3))
        0:       prebuf = 0;
        1:       prebuf = 4194303;
        default: prebuf = $urandom_range(hw);
      endcase
      set_regs(($urandom_range(1) != 0) ? 4095 : $urandom_range(4095), hw, prebuf,
               $urandom_range(30), $urandom_range(80));
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      run_burst(200, 45, 33, 20, span_hi);
    end
  endtask

  task automatic test_idle_ticks();
    set_regs(1024, 9600, 1920, 5, 12);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_req(mk_tick(1'b1));
    repeat (30) send_req(mk_tick(1'b0));
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_serial != hold_seen) begin
      hold_seen   <= hold_serial;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    playout_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_rsp.size() == 0) begin
        report_mismatch("result with none outstanding", status_o, 0);
      end else begin
        want = expected_rsp.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (slot_index_o != want.slot) report_mismatch("slot_index", slot_index_o, want.slot);
        if (out_len_o != want.len) report_mismatch("out_len", out_len_o, want.len);
        if (dropped_o != want.dropped) report_mismatch("dropped", dropped_o, want.dropped);
        if (retire_o != want.retire) report_mismatch("retire", retire_o, want.retire);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wd_count <= 0;
    else wd_count <= wd_count + 1;
    if (wd_count >= WD_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    op_i           = '0;
    pkt_len_i      = '0;
    span_samples_i = '0;
    terminator_i   = 1'b0;
    out_capacity_i = '0;
    produced_i     = 1'b0;
    out_stall_i    = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_serial    = 0;
    hold_seen      = 0;
    hold_left      = 0;
    wd_count       = 0;
    n_errors       = 0;
    n_sent         = 0;
    n_results      = 0;
    n_cfg_writes   = 0;
    n_dropped      = 0;
    n_full_drops   = 0;
    status_seen    = '{default: 0};
    cfg_max_bytes  = MAX_BYTES_RST;
    cfg_high_water = HIGH_WATER_RST;
    cfg_prebuf     = PREBUF_RST;
    cfg_retire     = RETIRE_RST;
    cfg_stall      = STALL_RST;
    ring_len       = '{default: '0};
    ring_spn       = '{default: '0};
    ring_head      = '0;
    ring_count     = '0;
    ring_span      = '0;
    ring_gate      = 1'b0;
    ring_idle      = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_ring_fill();
    test_zero_regs();
    test_backpressure();
    test_random_traffic();
    test_idle_ticks();

    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("ran %0d transactions, %0d results checked, %0d register writes",
             n_sent, n_results, n_cfg_writes);
    $display("ok/refused/not-ready/too-big %0d/%0d/%0d/%0d, %0d drops (%0d ring-full)",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             n_dropped, n_full_drops);
    if (n_errors == 0 && expected_rsp.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
